### rtl/core/ansi_sgr_terminal_parser_assert.svh
// assertion macros used by the sgr parser checker
`ifndef ANSI_SGR_TERMINAL_PARSER_ASSERT_SVH
`define ANSI_SGR_TERMINAL_PARSER_ASSERT_SVH

// implication in the same cycle
`define ASGR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sgr parser assertion failed");

// implication in the following cycle
`define ASGR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sgr parser assertion failed");

`endif

### rtl/core/asgr_pkg.sv
// types and constants for the ansi sgr terminal parser
package asgr_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_ESC    = 3'b010,
        MODE_CSI    = 3'b100
    } t_mode;

    typedef struct packed {
        logic       bold;
        logic [4:0] color;
    } t_attr;

    typedef struct packed {
        t_mode      mode;
        logic       after_cr;
        logic [7:0] param_value;
        logic       param_invalid;
        t_attr      cur;
        t_attr      pend;
    } t_state;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_out;
        logic       bold_on;
        logic [4:0] text_color;
    } t_result;

    localparam logic [1:0] ACT_INSERT       = 2'd0;
    localparam logic [1:0] ACT_CLEAR_INSERT = 2'd1;
    localparam logic [1:0] ACT_DELETE       = 2'd2;

    localparam logic [7:0] BYTE_NUL   = 8'h00;
    localparam logic [7:0] BYTE_BS    = 8'h08;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_ESC   = 8'h1B;
    localparam logic [7:0] BYTE_SEMI  = 8'h3B;
    localparam logic [7:0] BYTE_ZERO  = 8'h30;
    localparam logic [7:0] BYTE_NINE  = 8'h39;
    localparam logic [7:0] BYTE_LBRKT = 8'h5B;
    localparam logic [7:0] BYTE_M     = 8'h6D;
    localparam logic [7:0] FINAL_LO   = 8'h40;
    localparam logic [7:0] FINAL_HI   = 8'h7E;

    localparam logic [7:0] SGR_RESET      = 8'd0;
    localparam logic [7:0] SGR_BOLD       = 8'd1;
    localparam logic [7:0] SGR_NORMAL     = 8'd22;
    localparam logic [7:0] SGR_FG_DEFAULT = 8'd39;
    localparam logic [7:0] SGR_FG_LO      = 8'd30;
    localparam logic [7:0] SGR_FG_HI      = 8'd37;
    localparam logic [7:0] SGR_BRIGHT_LO  = 8'd90;
    localparam logic [7:0] SGR_BRIGHT_HI  = 8'd97;
    localparam logic [7:0] PARAM_MAX      = 8'd255;

endpackage

### rtl/core/asgr_step.sv
// next-state and result logic for one byte of the terminal stream
module asgr_step (
    input  asgr_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    output asgr_pkg::t_state  o_next,
    output logic              o_emit,
    output asgr_pkg::t_result o_result
);
    import asgr_pkg::*;

    function automatic t_attr apply_code(input t_attr pend, input logic [7:0] value,
                                         input logic invalid);
        logic [7:0] code;
        logic [7:0] diff;
        t_attr      res;
        begin
            code = invalid ? SGR_RESET : value;
            res  = pend;
            diff = 8'd0;
            if (code == SGR_RESET) begin
                res.bold  = 1'b0;
                res.color = 5'd0;
            end else if (code == SGR_BOLD) begin
                res.bold = 1'b1;
            end else if (code == SGR_NORMAL) begin
                res.bold = 1'b0;
            end else if (code == SGR_FG_DEFAULT) begin
                res.color = 5'd0;
            end else if (code >= SGR_FG_LO && code <= SGR_FG_HI) begin
                diff      = code - SGR_FG_LO + 8'd1;
                res.color = diff[4:0];
            end else if (code >= SGR_BRIGHT_LO && code <= SGR_BRIGHT_HI) begin
                diff      = code - SGR_BRIGHT_LO + 8'd9;
                res.color = diff[4:0];
            end
            return res;
        end
    endfunction

    t_attr       applied;
    logic [11:0] accum;
    logic        is_final;
    logic        is_digit;

    assign applied  = apply_code(i_state.pend, i_state.param_value, i_state.param_invalid);
    // value * 10 + digit, saturated below
    assign accum    = {1'b0, i_state.param_value, 3'b000} + {3'b000, i_state.param_value, 1'b0}
                      + {4'd0, i_byte - BYTE_ZERO};
    assign is_final = (i_byte >= FINAL_LO) && (i_byte <= FINAL_HI);
    assign is_digit = (i_byte >= BYTE_ZERO) && (i_byte <= BYTE_NINE);

    always_comb begin
        o_next   = i_state;
        o_emit   = 1'b0;
        o_result = '{action: ACT_INSERT, char_out: i_byte,
                     bold_on: i_state.cur.bold, text_color: i_state.cur.color};
        unique case (i_state.mode)
            MODE_ESC: begin
                if (i_byte == BYTE_LBRKT) begin
                    o_next.mode          = MODE_CSI;
                    o_next.param_value   = 8'd0;
                    o_next.param_invalid = 1'b0;
                    o_next.pend          = i_state.cur;
                end else begin
                    o_next.mode = MODE_NORMAL;
                end
                o_next.after_cr = 1'b0;
            end
            MODE_CSI: begin
                if (is_final) begin
                    if (i_byte == BYTE_M) begin
                        o_next.pend = applied;
                        o_next.cur  = applied;
                    end
                    o_next.mode          = MODE_NORMAL;
                    o_next.param_value   = 8'd0;
                    o_next.param_invalid = 1'b0;
                    o_next.after_cr      = 1'b0;
                end else if (i_byte == BYTE_SEMI) begin
                    o_next.pend          = applied;
                    o_next.param_value   = 8'd0;
                    o_next.param_invalid = 1'b0;
                end else if (is_digit) begin
                    o_next.param_value = (accum > 12'(PARAM_MAX)) ? PARAM_MAX : accum[7:0];
                end else begin
                    o_next.param_invalid = 1'b1;
                end
            end
            default: begin
                o_next.mode = MODE_NORMAL;
                if (i_byte == BYTE_ESC) begin
                    o_next.mode     = MODE_ESC;
                    o_next.after_cr = 1'b0;
                end else if (i_byte == BYTE_NUL) begin
                    o_next.after_cr = 1'b0;
                end else if (i_byte == BYTE_CR) begin
                    o_next.after_cr = 1'b1;
                end else if (i_byte == BYTE_BS) begin
                    o_emit   = 1'b1;
                    o_result = '{action: ACT_DELETE, char_out: 8'd0,
                                 bold_on: 1'b0, text_color: 5'd0};
                end else if (i_state.after_cr && i_byte != BYTE_LF) begin
                    o_emit          = 1'b1;
                    o_next.after_cr = 1'b0;
                    o_result.action = ACT_CLEAR_INSERT;
                end else begin
                    // lf keeps a pending carriage return
                    o_emit = 1'b1;
                end
            end
        endcase
    end

endmodule

### rtl/core/ansi_sgr_terminal_parser.sv
// top level of the ansi sgr terminal parser
// One terminal byte is taken per clock while o_in_stall is low. Each accepted byte is
// held in an input register, its parser state update and any result are worked out
// from that register, and a result (insert, clear line then insert, or delete) lands
// in an output register where it waits until taken. The state update between the input
// and result registers is combinational, so a byte can enter while a result waits.
// Bytes that only move the escape state (ESC, CSI contents, NUL, CR) give no result.
// A stall on the result side stalls the input only when a byte that gives a result
// meets a full result register.
module ansi_sgr_terminal_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_byte_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_action,
    output logic [7:0] o_char_out,
    output logic       o_bold_on,
    output logic [4:0] o_text_color
);
    import asgr_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_state     r_state;
    logic       r_out_valid;
    t_result    r_out;

    t_state     n_state;
    logic       step_emit;
    t_result    step_result;
    logic       out_free;
    logic       step_go;
    logic       in_free;

    asgr_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .o_next   (n_state),
        .o_emit   (step_emit),
        .o_result (step_result)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    // a byte without a result retires even when the output is blocked
    assign step_go    = r_in_valid && (!step_emit || out_free);
    assign in_free    = !r_in_valid || step_go;
    assign o_in_stall = !in_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{mode: MODE_NORMAL, after_cr: 1'b0, param_value: 8'd0,
                             param_invalid: 1'b0, cur: '0, pend: '0};
        end else begin
            if (in_free) begin
                r_in_valid <= i_in_valid;
            end
            if (step_go) begin
                r_state <= n_state;
            end
            if (step_go && step_emit) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_in_valid) begin
            r_in_byte <= i_byte_in;
        end
        if (step_go && step_emit) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_action     = r_out.action;
    assign o_char_out   = r_out.char_out;
    assign o_bold_on    = r_out.bold_on;
    assign o_text_color = r_out.text_color;

endmodule

### rtl/core/asgr_checker.sv
// port-level checks for the ansi sgr terminal parser, bound to the top level
`include "ansi_sgr_terminal_parser_assert.svh"

module asgr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_action,
    input logic [7:0] o_char_out,
    input logic       o_bold_on,
    input logic [4:0] o_text_color
);
    import asgr_pkg::*;

    logic [15:0] out_bits;
    logic        ctrl_char;

    assign out_bits  = {o_action, o_char_out, o_bold_on, o_text_color};
    assign ctrl_char = (o_char_out == BYTE_NUL) || (o_char_out == BYTE_CR) ||
                       (o_char_out == BYTE_BS) || (o_char_out == BYTE_ESC);

    // a blocked result keeps its content
    `ASGR_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(out_bits))

    // the input only waits behind a blocked result
    `ASGR_ASSERT_IMP(a_in_stall_cause, o_in_stall, o_out_valid && i_out_stall)

    `ASGR_ASSERT_IMP(a_delete_blank, o_out_valid && o_action == ACT_DELETE, out_bits[13:0] == 14'd0)

    `ASGR_ASSERT_IMP(a_color_range, o_out_valid, o_text_color <= 5'd16)

    // control bytes are consumed by the parser, never inserted
    `ASGR_ASSERT_IMP(a_no_ctrl_insert, o_out_valid && o_action != ACT_DELETE, !ctrl_char)

endmodule

bind ansi_sgr_terminal_parser asgr_checker u_asgr_checker (.*);
